// ===== hdl/pida_pkg.sv =====
// package for the positional insert/delete array
// holds widths, command and status codes, cell control and word types
// no dependencies
package pida_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int CMD_W        = 2;
   localparam int POS_W        = 6;
   localparam int ELEM_W       = 32;
   localparam int INDEX_W      = 7;
   localparam int STATUS_W     = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LIST_FWD = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LIST_REV = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_DELETE,
      OP_ROT_UP,
      OP_ROT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic [POS_W-1:0]         position;
      logic signed [ELEM_W-1:0] value;
   } cell_ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [ELEM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [INDEX_W-1:0]       index;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_type;

endpackage

// ===== hdl/positional_insert_delete_array.sv =====
// top level of the positional insert/delete array
// holds the command decoder, count, listing sequencer and the ring of cells
// depends on pida_pkg and pida_cell
//
// usage:
//   a command word (command, 1-based position, value) is taken on req_data at a
//   rising edge with start high and busy low. results leave on rsp_data, each
//   marked by rsp_valid for exactly one cycle; the receiver cannot hold them off.
//   insert and delete shift all cells from the given position upward at once
//   in the accepting cycle; their single status word appears in the cycle
//   after acceptance; busy stays low, so these can be issued every cycle.
//   a listing rotates the whole ring of CAPACITY cells one place a cycle, with
//   the result taken from the end cell, and so keeps busy high until the ring
//   has come full circle; no command is taken while busy.
//   forward words appear in index order from 1 up to count; reversed words
//   appear from count down to 1, the last one in the same cycle that busy
//   drops. the final word of each command has last set.
//   listing an empty array gives one empty status word in the cycle after
//   acceptance, without going busy.
//   reset empties the array (count to zero) and drops any listing under way;
//   cell contents are not cleared and are only read once written.
module positional_insert_delete_array #(
   parameter int CAPACITY = pida_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pida_pkg::req_type req_data,
   output logic              rsp_valid,
   output pida_pkg::rsp_type rsp_data
);

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int KW   = $clog2(CAPACITY);
   localparam int CMPW = ((CW > pida_pkg::POS_W) ? CW : pida_pkg::POS_W) + 1;

   typedef enum logic {
      STATE_IDLE,
      STATE_LIST
   } state_type;

   state_type              state_ff, state_in;
   logic [KW-1:0]          k_ff, k_in;
   logic                   rev_ff, rev_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pida_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   pida_pkg::cell_ctl_type ctl;
   logic signed [pida_pkg::ELEM_W-1:0] elems [CAPACITY];

   logic                   accept;
   logic [CMPW-1:0]        pos_ext;
   logic [CMPW-1:0]        cnt_ext;
   logic [CMPW-1:0]        k_ext;
   logic                   full;

   assign busy    = (state_ff == STATE_LIST);
   assign accept  = start & ~busy;
   assign pos_ext = CMPW'(req_data.position);
   assign cnt_ext = CMPW'(count_ff);
   assign k_ext   = CMPW'(k_ff);
   assign full    = (count_ff == CW'(CAPACITY));

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      rev_in       = rev_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rsp_data_in.last = 1'b1;
      ctl.op       = pida_pkg::OP_HOLD;
      ctl.position = req_data.position;
      ctl.value    = req_data.value;

      if (state_ff == STATE_LIST) begin
         ctl.op = rev_ff ? pida_pkg::OP_ROT_UP : pida_pkg::OP_ROT_DOWN;
         k_in   = k_ff + KW'(1);
         if (k_ff == KW'(CAPACITY - 1)) begin
            state_in = STATE_IDLE;
         end
         rsp_data_in.status = pida_pkg::STATUS_OK;
         if (rev_ff) begin
            // end cell holds element CAPACITY-k once the empty tail has passed
            rsp_valid_in          = (k_ext + cnt_ext >= CMPW'(CAPACITY));
            rsp_data_in.element   = elems[CAPACITY-1];
            rsp_data_in.index     = pida_pkg::INDEX_W'(CMPW'(CAPACITY) - k_ext);
            rsp_data_in.last      = (k_ff == KW'(CAPACITY - 1));
         end else begin
            rsp_valid_in          = (k_ext < cnt_ext);
            rsp_data_in.element   = elems[0];
            rsp_data_in.index     = pida_pkg::INDEX_W'(k_ext + CMPW'(1));
            rsp_data_in.last      = (k_ext + CMPW'(1) == cnt_ext);
         end
      end else if (accept) begin
         case (req_data.command)
            pida_pkg::CMD_INSERT: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_data_in.status = pida_pkg::STATUS_FULL;
               end else if (pos_ext == '0 || pos_ext > cnt_ext + CMPW'(1)) begin
                  rsp_data_in.status = pida_pkg::STATUS_BADPOS;
               end else begin
                  ctl.op             = pida_pkg::OP_INSERT;
                  count_in           = count_ff + CW'(1);
                  rsp_data_in.status = pida_pkg::STATUS_OK;
               end
            end
            pida_pkg::CMD_DELETE: begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_data_in.status = pida_pkg::STATUS_EMPTY;
               end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
                  rsp_data_in.status = pida_pkg::STATUS_BADPOS;
               end else begin
                  ctl.op             = pida_pkg::OP_DELETE;
                  count_in           = count_ff - CW'(1);
                  rsp_data_in.status = pida_pkg::STATUS_OK;
               end
            end
            pida_pkg::CMD_LIST_FWD, pida_pkg::CMD_LIST_REV: begin
               if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = pida_pkg::STATUS_EMPTY;
               end else begin
                  state_in = STATE_LIST;
                  k_in     = '0;
                  rev_in   = (req_data.command == pida_pkg::CMD_LIST_REV);
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         k_ff         <= '0;
         rev_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rev_ff       <= rev_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ring of cells: each one sees its two neighbors, the ends wrap around
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      pida_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .lower_elem (elems[(i + CAPACITY - 1) % CAPACITY]),
         .upper_elem (elems[(i + 1) % CAPACITY]),
         .elem       (elems[i])
      );
   end

endmodule

// ===== hdl/pida_cell.sv =====
// one storage cell of the array chain
// takes from its lower or upper neighbor, the broadcast value, or holds
// depends on pida_pkg
module pida_cell #(
   parameter int INDEX = 0
) (
   input  logic                                  clock,
   input  pida_pkg::cell_ctl_type                ctl,
   input  logic signed [pida_pkg::ELEM_W-1:0]    lower_elem,
   input  logic signed [pida_pkg::ELEM_W-1:0]    upper_elem,
   output logic signed [pida_pkg::ELEM_W-1:0]    elem
);

   localparam logic [pida_pkg::POS_W:0] IDX      = (pida_pkg::POS_W + 1)'(INDEX);
   localparam logic [pida_pkg::POS_W:0] IDX_NEXT = (pida_pkg::POS_W + 1)'(INDEX + 1);

   logic signed [pida_pkg::ELEM_W-1:0] elem_ff;
   logic signed [pida_pkg::ELEM_W-1:0] elem_in;
   logic [pida_pkg::POS_W:0]           pos_ext;
   logic                               at_pos;
   logic                               above_pos;
   logic                               at_or_above_pos;

   assign pos_ext         = {1'b0, ctl.position};
   // 1-based position: this cell sits at the position when position-1 == INDEX
   assign at_pos          = (pos_ext == IDX_NEXT);
   assign above_pos       = (pos_ext <= IDX);
   assign at_or_above_pos = (pos_ext <= IDX_NEXT);

   always_comb begin
      elem_in = elem_ff;
      case (ctl.op)
         pida_pkg::OP_INSERT: begin
            if (at_pos) begin
               elem_in = ctl.value;
            end else if (above_pos) begin
               elem_in = lower_elem;
            end
         end
         pida_pkg::OP_DELETE: begin
            if (at_or_above_pos) begin
               elem_in = upper_elem;
            end
         end
         pida_pkg::OP_ROT_UP:   elem_in = lower_elem;
         pida_pkg::OP_ROT_DOWN: elem_in = upper_elem;
         default:               elem_in = elem_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign elem = elem_ff;

endmodule
